@@ rtl/pmfb_pkg.sv @@
// Shared types and constants for the page-organized monochrome frame store.
`timescale 1ns / 1ps

package pmfb_pkg;

  localparam int REQ_W  = 3;
  localparam int COL_W  = 7;
  localparam int ROW_W  = 6;
  localparam int BADR_W = 10;
  localparam int DATA_W = 8;
  // Page index carried by a row number (row / 8).
  localparam int PG_W   = ROW_W - 3;

  localparam logic [DATA_W-1:0] BYTE_FULL = 8'hFF;

  typedef enum logic [REQ_W-1:0] {
    REQ_SET   = 3'd0,
    REQ_CLR   = 3'd1,
    REQ_LINE  = 3'd2,
    REQ_WIPE  = 3'd3,
    REQ_READ  = 3'd4
  } req_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RMW_RD,
    ST_RMW_WR,
    ST_RB_RD,
    ST_RB_OUT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // latch the incoming transaction
    logic clr_start;  // restart the clearing sweep at address zero
    logic clr_step;   // zero one store byte and advance the sweep
    logic rd_issue;   // read the byte of the current line page
    logic wr_commit;  // write the modified byte and advance the page
    logic rb_issue;   // read the byte asked for by a read transaction
    logic rb_load;    // move the read byte into the output register
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic skip;       // the pixel or line touches nothing in the store
    logic last_page;  // the current page is the last one to write
    logic clr_done;   // the sweep is at the last store byte
    logic out_free;   // the output register can take a new byte
  } dp_stat_t;

endpackage

@@ rtl/page_mono_framebuffer_engine_top.sv @@
// Top level of the page-organized monochrome frame store engine.
// Set or clear pixel: accept, store read, store write; a pixel outside the store is skipped.
// Vertical line: one read-modify-write per page touched.
// Read byte: accept, store read, then load into the output register, after which the engine is idle again;
// a read waits while an earlier result is still stalled at the output.
// Clear all: the sweep zeroes one byte per cycle through the single store port.
// After reset the same sweep runs before the first transaction.
`timescale 1ns / 1ps

module page_mono_framebuffer_engine_top #(
  parameter int COLUMNS = 128,
  parameter int PAGES   = 8
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [pmfb_pkg::REQ_W-1:0]   in_req_type,
  input  logic [pmfb_pkg::COL_W-1:0]   in_col,
  input  logic [pmfb_pkg::ROW_W-1:0]   in_row_a,
  input  logic [pmfb_pkg::ROW_W-1:0]   in_row_b,
  input  logic [pmfb_pkg::BADR_W-1:0]  in_byte_addr,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [pmfb_pkg::DATA_W-1:0]  out_read_data
);
  import pmfb_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  pmfb_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_req_type (in_req_type),
    .stat        (stat),
    .cmd         (cmd)
  );

  pmfb_dp #(
    .COLUMNS (COLUMNS),
    .PAGES   (PAGES)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .stat          (stat),
    .in_req_type   (in_req_type),
    .in_col        (in_col),
    .in_row_a      (in_row_a),
    .in_row_b      (in_row_b),
    .in_byte_addr  (in_byte_addr),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_read_data (out_read_data)
  );

endmodule

@@ rtl/pmfb_ctrl.sv @@
// Controller state machine: sequences clearing, read-modify-write and reads.
`timescale 1ns / 1ps

module pmfb_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         in_req_type,
  input  pmfb_pkg::dp_stat_t stat,
  output pmfb_pkg::dp_cmd_t  cmd
);
  import pmfb_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (stat.clr_done) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          case (in_req_type)
            REQ_SET, REQ_CLR, REQ_LINE: state_nxt = ST_RMW_RD;
            REQ_WIPE:                   state_nxt = ST_CLEAR;
            REQ_READ:                   state_nxt = ST_RB_RD;
            default:                    state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_RMW_RD: begin
        state_nxt = stat.skip ? ST_IDLE : ST_RMW_WR;
      end
      ST_RMW_WR: begin
        state_nxt = stat.last_page ? ST_IDLE : ST_RMW_RD;
      end
      ST_RB_RD: begin
        state_nxt = ST_RB_OUT;
      end
      ST_RB_OUT: begin
        if (stat.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clr_step = 1'b1;
      end
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          case (in_req_type)
            REQ_SET, REQ_CLR, REQ_LINE, REQ_READ: cmd.load = 1'b1;
            REQ_WIPE:                             cmd.clr_start = 1'b1;
            default:                              cmd = '0;
          endcase
        end
      end
      ST_RMW_RD: begin
        cmd.rd_issue = !stat.skip;
      end
      ST_RMW_WR: begin
        cmd.wr_commit = 1'b1;
      end
      ST_RB_RD: begin
        cmd.rb_issue = 1'b1;
      end
      ST_RB_OUT: begin
        cmd.rb_load = stat.out_free;
      end
      default: cmd = '0;
    endcase
  end

`ifndef SYNTHESIS
  // A write of a line page always follows the read of that page.
  a_wr_after_rd: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_RMW_WR |-> $past(state_r) == ST_RMW_RD)
    else $error("line page written without a preceding read");

  // An accepted read transaction goes straight to the store read.
  a_read_path: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE && in_valid && in_req_type == REQ_READ) |=> state_r == ST_RB_RD)
    else $error("read transaction not sequenced to the store read");
`endif

endmodule

@@ rtl/pmfb_dp.sv @@
// Datapath: frame store memory, line page walker, clearing sweep and output register.
`timescale 1ns / 1ps

module pmfb_dp #(
  parameter int COLUMNS = 128,
  parameter int PAGES   = 8
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  pmfb_pkg::dp_cmd_t            cmd,
  output pmfb_pkg::dp_stat_t           stat,
  input  logic [pmfb_pkg::REQ_W-1:0]   in_req_type,
  input  logic [pmfb_pkg::COL_W-1:0]   in_col,
  input  logic [pmfb_pkg::ROW_W-1:0]   in_row_a,
  input  logic [pmfb_pkg::ROW_W-1:0]   in_row_b,
  input  logic [pmfb_pkg::BADR_W-1:0]  in_byte_addr,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [pmfb_pkg::DATA_W-1:0]  out_read_data
);
  import pmfb_pkg::*;

  localparam int DEPTH  = COLUMNS * PAGES;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);
  localparam logic [ADDR_W-1:0] COL_STEP  = ADDR_W'(COLUMNS);

  logic [DATA_W-1:0] mem [DEPTH];

  // Latched transaction.
  logic [COL_W-1:0]  col_r;
  logic [ROW_W-1:0]  lo_r;
  logic [ROW_W-1:0]  hi_r;
  logic              op_clr_r;
  logic              skip_r;
  logic [PG_W-1:0]   page_r;
  logic [PG_W-1:0]   last_pg_r;
  logic [BADR_W-1:0] byte_addr_r;
  logic              rb_ok_r;

  logic [ADDR_W-1:0] clr_cnt_r;
  logic [DATA_W-1:0] rdata_r;
  logic              out_valid_r;
  logic [DATA_W-1:0] out_data_r;

  logic [ROW_W-1:0]  lo_nxt;
  logic [ROW_W-1:0]  hi_nxt;
  logic [PG_W-1:0]   hi_pg;
  logic [ADDR_W-1:0] rmw_addr;
  logic [ADDR_W-1:0] rd_addr;
  logic [DATA_W-1:0] lo_mask;
  logic [DATA_W-1:0] hi_mask;
  logic [DATA_W-1:0] mask;
  logic [DATA_W-1:0] wdata;

  // A pixel command is a line of one row.
  always_comb begin
    if (in_req_type == REQ_LINE && in_row_b < in_row_a) begin
      lo_nxt = in_row_b;
      hi_nxt = in_row_a;
    end else if (in_req_type == REQ_LINE) begin
      lo_nxt = in_row_a;
      hi_nxt = in_row_b;
    end else begin
      lo_nxt = in_row_a;
      hi_nxt = in_row_a;
    end
  end

  assign hi_pg = hi_nxt[ROW_W-1:3];

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      col_r       <= in_col;
      lo_r        <= lo_nxt;
      hi_r        <= hi_nxt;
      op_clr_r    <= (in_req_type == REQ_CLR);
      skip_r      <= (32'(in_col) >= COLUMNS) || (32'(lo_nxt[ROW_W-1:3]) >= PAGES);
      page_r      <= lo_nxt[ROW_W-1:3];
      // Pages beyond the store are dropped from the end of the line.
      last_pg_r   <= (32'(hi_pg) >= PAGES) ? PG_W'(PAGES - 1) : hi_pg;
      byte_addr_r <= in_byte_addr;
      rb_ok_r     <= (32'(in_byte_addr) < DEPTH);
    end else if (cmd.wr_commit) begin
      page_r <= page_r + PG_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clr_start) begin
      clr_cnt_r <= '0;
    end else if (cmd.clr_step) begin
      clr_cnt_r <= clr_cnt_r + ADDR_W'(1);
    end
  end

  assign rmw_addr = ADDR_W'(col_r) + ADDR_W'(page_r) * COL_STEP;
  assign rd_addr  = cmd.rb_issue ? ADDR_W'(byte_addr_r) : rmw_addr;

  // Partial masks on the first and last page of a line, full bytes between.
  assign lo_mask = (page_r == lo_r[ROW_W-1:3]) ? (BYTE_FULL << lo_r[2:0]) : BYTE_FULL;
  assign hi_mask = (page_r == hi_r[ROW_W-1:3]) ? (BYTE_FULL >> (3'd7 - hi_r[2:0])) : BYTE_FULL;
  assign mask    = lo_mask & hi_mask;
  assign wdata   = op_clr_r ? (rdata_r & ~mask) : (rdata_r | mask);

  always_ff @(posedge clk) begin
    if (cmd.clr_step) begin
      mem[clr_cnt_r] <= '0;
    end else if (cmd.wr_commit) begin
      mem[rmw_addr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_issue || cmd.rb_issue) begin
      rdata_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.rb_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rb_load) begin
      out_data_r <= rb_ok_r ? rdata_r : '0;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_read_data = out_data_r;

  assign stat.skip      = skip_r;
  assign stat.last_page = (page_r == last_pg_r);
  assign stat.clr_done  = (clr_cnt_r == LAST_ADDR);
  assign stat.out_free  = !out_valid_r || !out_stall;

`ifndef SYNTHESIS
  // The clearing sweep owns the store; no other read or write may be issued alongside it.
  a_clr_excl: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clr_step |-> !cmd.rd_issue && !cmd.rb_issue && !cmd.wr_commit)
    else $error("store access issued during the clearing sweep");

  // The line walker never runs past its last page.
  a_page_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr_commit |-> page_r <= last_pg_r && !skip_r)
    else $error("line write beyond its last page");

  // A result appears only when a read byte is loaded.
  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(cmd.rb_load))
    else $error("output became valid without a read");
`endif

endmodule
